// ----- rtl/sha256_pkg.sv -----
// SHA-256 constants, word type and round functions.
package sha256_pkg;

  typedef logic [31:0] word_t;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned LEN_POS     = 56;
  localparam logic [7:0]  PAD_BYTE    = 8'h80;

  localparam word_t H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sig0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sig1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sig0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ----- rtl/sha256_byte_stream_hasher_top.sv -----
// SHA-256 byte-stream hasher: byte shift buffer, one-round-per-cycle compression, digest out.
//
// Takes one message byte per request (in_tuser = 0) or a finish request (in_tuser = 1) and
// answers a finish with the eight digest words, word 0 first, in_tready low meanwhile. The
// byte that fills a 64-byte block starts a compression on the shared round unit, which does
// one of the 64 rounds per cycle and then folds the result into the chain value; in_tready
// is low meanwhile, so no byte is taken during a compression. A finish feeds pad and length
// bytes through the same byte path one per cycle, pausing for a compression (a second block
// when fill is 56 or more), runs one or two compressions, then holds each digest word until
// taken. After the last word the hasher is back in its initial state.
module sha256_byte_stream_hasher_top
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]   state_r, state_nxt;
  logic [5:0]   fill_r, fill_nxt;
  logic [63:0]  len_r, len_nxt;
  logic [511:0] buf_r, buf_nxt;
  word_t        chain_r [8];
  word_t        chain_nxt [8];
  word_t        v_r [8];
  word_t        v_nxt [8];
  logic [5:0]   rnd_r, rnd_nxt;
  logic [2:0]   idx_r, idx_nxt;
  logic         fin_r, fin_nxt;
  logic         wrap_r, wrap_nxt;
  logic         pad80_r, pad80_nxt;

  logic         push;
  logic [7:0]   push_byte;
  logic [7:0]   len_byte;
  logic         in_acc;
  word_t        t1, t2, w_new;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = chain_r[0];
  assign out_tuser  = idx_r;
  assign out_tlast  = (idx_r == 3'd7);
  assign in_acc     = in_tvalid && in_tready;

  // length bytes go out most significant first at fill 56..63
  assign len_byte = 8'(len_r >> {~fill_r[2:0], 3'b000});

  // round unit; the buffer acts as the 16-word schedule window, word 0 on top
  assign t1 = v_r[7] + big_sig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + ROUND_K[rnd_r] + buf_r[511:480];
  assign t2 = big_sig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  assign w_new = small_sig1(buf_r[63:32]) + buf_r[223:192] + small_sig0(buf_r[479:448])
               + buf_r[511:480];

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    len_nxt   = len_r;
    buf_nxt   = buf_r;
    chain_nxt = chain_r;
    v_nxt     = v_r;
    rnd_nxt   = rnd_r;
    idx_nxt   = idx_r;
    fin_nxt   = fin_r;
    wrap_nxt  = wrap_r;
    pad80_nxt = pad80_r;
    push      = 1'b0;
    push_byte = 8'h00;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!in_tuser) begin
            push      = 1'b1;
            push_byte = in_tdata;
            len_nxt   = len_r + 64'd8;
          end else begin
            fin_nxt   = 1'b1;
            pad80_nxt = 1'b1;
            wrap_nxt  = (fill_r >= 6'(LEN_POS));
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        push      = 1'b1;
        pad80_nxt = 1'b0;
        if (pad80_r) begin
          push_byte = PAD_BYTE;
        end else if (fill_r >= 6'(LEN_POS) && !wrap_r) begin
          push_byte = len_byte;
        end
      end
      S_ROUND: begin
        for (int j = 7; j > 0; j--) begin
          v_nxt[j] = v_r[j-1];
        end
        v_nxt[4] = v_r[3] + t1;
        v_nxt[0] = t1 + t2;
        buf_nxt  = {buf_r[479:0], w_new};
        rnd_nxt  = rnd_r + 6'd1;
        if (rnd_r == 6'(BLOCK_BYTES - 1)) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        for (int j = 0; j < 8; j++) begin
          chain_nxt[j] = chain_r[j] + v_r[j];
        end
        priority if (fin_r && wrap_r) begin
          wrap_nxt  = 1'b0;
          state_nxt = S_PAD;
        end else if (fin_r) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          // rotate the next word down to the output
          for (int j = 0; j < 7; j++) begin
            chain_nxt[j] = chain_r[j+1];
          end
          chain_nxt[7] = chain_r[0];
          idx_nxt      = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            chain_nxt = H_INIT;
            len_nxt   = '0;
            fin_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // shared byte path for data, pad and length bytes
    if (push) begin
      buf_nxt  = {buf_r[503:0], push_byte};
      fill_nxt = fill_r + 6'd1;
      if (fill_r == 6'(BLOCK_BYTES - 1)) begin
        v_nxt     = chain_r;
        rnd_nxt   = '0;
        state_nxt = S_ROUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      len_r   <= '0;
      chain_r <= H_INIT;
      rnd_r   <= '0;
      idx_r   <= '0;
      fin_r   <= 1'b0;
      wrap_r  <= 1'b0;
      pad80_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      len_r   <= len_nxt;
      chain_r <= chain_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
      fin_r   <= fin_nxt;
      wrap_r  <= wrap_nxt;
      pad80_r <= pad80_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    v_r   <= v_nxt;
  end

endmodule

// ----- verif/sha256_byte_stream_hasher_top_tb.sv -----
// Self-checking bench for the SHA-256 byte-stream hasher: random byte messages against a digest model.
module sha256_byte_stream_hasher_top_tb
  import sha256_pkg::*;
;

  localparam bit CMD_ABSORB = 1'b0;
  localparam bit CMD_FINISH = 1'b1;

  localparam int RAND_ITEMS   = 118;
  localparam int IDLE_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 300;
  localparam int MAX_REPORTS  = 10;

  localparam logic [7:0] MSG_PAD = 8'h80;
  localparam int LENGTH_SLOT = 56;

  localparam word_t SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct {
    bit         cmd;
    logic [7:0] data;
    bit         drain_first;
  } hash_req_t;

  typedef struct packed {
    word_t      word;
    logic [2:0] index;
    logic       last;
  } digest_beat_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_CHOKED} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  hash_req_t    req_queue[$];
  digest_beat_t digest_due[$];
  hash_req_t    req_on_bus;

  // model state
  word_t      chain_val [8];
  logic [7:0] msg_block [64];
  logic [5:0] block_fill;
  logic [63:0] msg_bits;

  int reqs_total;
  int reqs_taken = 0;
  int fail_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int idle_cycles = 0;
  int rx_left = 0;
  rx_mode_t rx_mode = RX_OPEN;

  sha256_byte_stream_hasher_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic word_t ror32(input word_t x, input int n);
    logic [63:0] dbl;
    dbl = {x, x} >> n;
    return dbl[31:0];
  endfunction

  function automatic void clear_hash();
    for (int i = 0; i < 8; i++) chain_val[i] = SHA_IV[i];
    for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    block_fill = '0;
    msg_bits = '0;
  endfunction

  function automatic void fold_block();
    word_t sched [64];
    word_t v [8];
    word_t s0, s1, t1, t2;
    for (int i = 0; i < 16; i++)
      sched[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3);
      s1 = ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10);
      sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = chain_val[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + sched[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_val[i] = chain_val[i] + v[i];
  endfunction

  // Advance the model by one accepted request; a finish queues the eight digest words.
  function automatic void hash_request(input hash_req_t r);
    digest_beat_t beat;
    int fill;
    fill = int'(block_fill);
    if (r.cmd == CMD_ABSORB) begin
      msg_block[fill] = r.data;
      block_fill = block_fill + 6'd1;
      msg_bits = msg_bits + 64'd8;
      if (block_fill == 6'd0) fold_block();
    end else begin
      msg_block[fill] = MSG_PAD;
      for (int i = fill + 1; i < 64; i++) msg_block[i] = 8'h00;
      // no room for the length: close this block and pad a second one
      if (fill + 1 > LENGTH_SLOT) begin
        fold_block();
        for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) msg_block[LENGTH_SLOT + i] = msg_bits[63 - 8*i -: 8];
      fold_block();
      for (int i = 0; i < 8; i++) begin
        beat.word  = chain_val[i];
        beat.index = 3'(i);
        beat.last  = (i == 7);
        digest_due.push_back(beat);
      end
      clear_hash();
    end
  endfunction

  function automatic void add_req(input bit cmd, input logic [7:0] data, input bit drain);
    hash_req_t r;
    r.cmd = cmd;
    r.data = data;
    r.drain_first = drain;
    req_queue.push_back(r);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'h00;
      in_tuser  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        hash_request(req_on_bus);
        reqs_taken <= reqs_taken + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (req_queue.size() == 0 ||
                     (req_queue[0].drain_first && digest_due.size() != 0)) begin
          in_tvalid <= 1'b0;
        end else begin
          req_on_bus = req_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= req_on_bus.data;
          in_tuser  <= req_on_bus.cmd;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // receiver stall pattern: open, coin-flip and choked spells of random length
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_left <= $urandom_range(16, 160);
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:  out_tready <= 1'b1;
      RX_COIN:  out_tready <= 1'($urandom_range(0, 1));
      default:  out_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // digest monitor
  always @(posedge clk) begin
    digest_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_due.size() == 0) begin
        fail_count <= fail_count + 1;
        if (fail_count < MAX_REPORTS)
          $display("unexpected digest word: word=%h index=%0d last=%b",
                   out_tdata, out_tuser, out_tlast);
      end else begin
        want = digest_due.pop_front();
        if (out_tdata !== want.word || out_tuser !== want.index || out_tlast !== want.last) begin
          fail_count <= fail_count + 1;
          if (fail_count < MAX_REPORTS)
            $display("digest mismatch: expected word=%h index=%0d last=%b, got word=%h index=%0d last=%b",
                     want.word, want.index, want.last, out_tdata, out_tuser, out_tlast);
        end
      end
    end
  end

  // watchdog: give up when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int n_rand;
    int len;
    bit drain;
    clear_hash();

    // empty message, with the byte field set to show it is ignored
    add_req(CMD_FINISH, 8'hff, 1'b0);
    // "abc"
    add_req(CMD_ABSORB, 8'h61, 1'b0);
    add_req(CMD_ABSORB, 8'h62, 1'b0);
    add_req(CMD_ABSORB, 8'h63, 1'b0);
    add_req(CMD_FINISH, 8'h00, 1'b0);
    // byte extremes and the pad pattern as data
    add_req(CMD_ABSORB, 8'h00, 1'b0);
    add_req(CMD_ABSORB, 8'hff, 1'b0);
    add_req(CMD_ABSORB, 8'h80, 1'b0);
    add_req(CMD_ABSORB, 8'h7f, 1'b0);
    add_req(CMD_FINISH, 8'h55, 1'b0);
    // back-to-back finishes
    add_req(CMD_FINISH, 8'haa, 1'b1);
    add_req(CMD_FINISH, 8'h00, 1'b0);

    // random messages, biased towards the block and length-field boundaries
    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      case ($urandom_range(0, 3))
        0:       len = $urandom_range(0, 3);
        1:       len = $urandom_range(52, 60);
        2:       len = $urandom_range(61, 66);
        default: len = $urandom_range(4, 40);
      endcase
      // trim the last message to the request budget
      if (len > RAND_ITEMS - n_rand - 1) len = RAND_ITEMS - n_rand - 1;
      drain = (n_rand == 0) || ($urandom_range(0, 5) == 0);
      for (int k = 0; k < len; k++)
        add_req(CMD_ABSORB, 8'($urandom_range(0, 255)), drain && (k == 0));
      add_req(CMD_FINISH, 8'($urandom_range(0, 255)), drain && (len == 0));
      n_rand = n_rand + len + 1;
    end
    reqs_total = req_queue.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (reqs_taken != reqs_total) @(posedge clk);
    while (digest_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0 && digest_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/sha256_pkg.sv
rtl/sha256_byte_stream_hasher_top.sv
verif/sha256_byte_stream_hasher_top_tb.sv
